// ----- sv/fsts_pkg.sv -----
package fsts_pkg;

	// Field and register widths
	localparam int unsigned IDX_W      = 16;
	localparam int unsigned STEP_W     = 31;
	localparam int unsigned AMP_W      = 16;
	localparam int unsigned CNT_W      = 16;
	localparam int unsigned CFG_DATA_W = 31;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned VALUE_W    = 16;

	// Quarter-wave sine table
	localparam int unsigned SINE_DEPTH = 1024;
	localparam int unsigned ADDR_W     = $clog2(SINE_DEPTH);
	localparam int unsigned POS_W      = ADDR_W + 2;
	localparam int unsigned PHASE_W    = 32;
	localparam int unsigned SINE_W     = 15;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam int unsigned TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

	// Envelope: fade is one eighth of the tone, quotient in Q0.16
	localparam int unsigned FADE_SHIFT = 3;
	localparam int unsigned FADE_W     = CNT_W - FADE_SHIFT;
	localparam int unsigned DIV_STEPS  = 16;
	localparam int unsigned ENV_W      = DIV_STEPS + 1;

	// Output scaling
	localparam int unsigned TONE_SCALE = 30000;
	localparam int unsigned SCALE_W    = 15;
	localparam int unsigned AE_W       = ENV_W + AMP_W - 1;
	localparam int unsigned SK_W       = SINE_W + SCALE_W;
	localparam int unsigned PROD_W     = AE_W + SK_W;
	localparam int unsigned RES_SHIFT  = 46;
	localparam int unsigned MAG_W      = 16;
	localparam logic [AMP_W-1:0] AMP_FULL = AMP_W'(32768);

	// Register reset values
	localparam logic [STEP_W-1:0] PHASE_STEP_RST   = STEP_W'(171409126);
	localparam logic [AMP_W-1:0]  AMPLITUDE_RST    = AMP_W'(16384);
	localparam logic [CNT_W-1:0]  SAMPLE_COUNT_RST = CNT_W'(2205);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PHASE_STEP   = 2'd0,
		CFG_AMPLITUDE    = 2'd1,
		CFG_SAMPLE_COUNT = 2'd2
	} cfg_idx_t;

	typedef logic [SINE_W-1:0] sine_rom_t [0:SINE_DEPTH];

	// Word state while the envelope divider works on it
	typedef struct packed {
		logic                  past;
		logic                  full;
		logic                  quad_hi;
		logic [SINE_W-1:0]     sine;
		logic [AMP_W-1:0]      amp;
		logic [FADE_W-1:0]     fade;
		logic [FADE_W-1:0]     rem;
		logic [DIV_STEPS-1:0]  quo;
	} div_t;

	// Taylor series in Q30, rounded to Q15 and capped
	function automatic sine_rom_t build_sine();
		sine_rom_t   rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] q;
		for (int k = 0; k <= SINE_DEPTH; k++) begin
			x = (64'(k) * HALF_PI_Q30) / 64'(SINE_DEPTH);
			x2 = (x * x) >> 30;
			term = x;
			sum = x;
			for (int n = 1; n <= 7; n++) begin
				term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[n]);
				if (n[0]) begin
					sum = (sum >= term) ? sum - term : 64'd0;
				end else begin
					sum = sum + term;
				end
			end
			q = (sum + 64'd16384) >> 15;
			if (q > 64'd32767) begin
				q = 64'd32767;
			end
			rom[k] = SINE_W'(q);
		end
		return rom;
	endfunction

	// One restoring step: one quotient bit
	function automatic div_t div_step(div_t d);
		div_t            o;
		logic [FADE_W:0] r2;
		o = d;
		r2 = {d.rem, 1'b0};
		if (r2 >= {1'b0, d.fade}) begin
			o.rem = FADE_W'(r2 - {1'b0, d.fade});
			o.quo = {d.quo[DIV_STEPS-2:0], 1'b1};
		end else begin
			o.rem = r2[FADE_W-1:0];
			o.quo = {d.quo[DIV_STEPS-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage

// ----- sv/faded_sine_tone_sample_core.sv -----
// Channel   Dir  Handshake             Payload
// in        in   in_valid / in_stall   sample_index[15:0]
// out       out  out_valid / out_stall sample_value[15:0] signed, past_end
// cfg       in   cfg_write_en          cfg_index[1:0], cfg_data[30:0]
//
// One word per cycle unless out_stall holds the pipe; stages: phase multiply, table read,
// 16 divider stages of one envelope bit each, two multiply stages, output.
// The envelope divider sets the depth; the sine ROM read is registered.
// Reset clears every stage valid bit and loads the register defaults.
// Each stage loads when it is empty or its successor loads, so bubbles close
// up under out_stall and nothing is dropped or repeated.
module faded_sine_tone_sample_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write_en,
	input  logic [fsts_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fsts_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [fsts_pkg::IDX_W-1:0]           sample_index,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [fsts_pkg::VALUE_W-1:0]  sample_value,
	output logic                                 past_end
);

	localparam int unsigned DivSteps = fsts_pkg::DIV_STEPS;
	localparam fsts_pkg::sine_rom_t SineRom = fsts_pkg::build_sine();

	// Config registers
	logic [fsts_pkg::STEP_W-1:0] phase_step_q;
	logic [fsts_pkg::AMP_W-1:0]  amplitude_q;
	logic [fsts_pkg::CNT_W-1:0]  sample_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q   <= fsts_pkg::PHASE_STEP_RST;
			amplitude_q    <= fsts_pkg::AMPLITUDE_RST;
			sample_count_q <= fsts_pkg::SAMPLE_COUNT_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				fsts_pkg::CFG_PHASE_STEP:   phase_step_q <= cfg_data;
				fsts_pkg::CFG_AMPLITUDE:    amplitude_q <= cfg_data[fsts_pkg::AMP_W-1:0];
				fsts_pkg::CFG_SAMPLE_COUNT: sample_count_q <= cfg_data[fsts_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage registers
	logic                          vld_s1, past_s1, full_s1;
	logic [fsts_pkg::FADE_W-1:0]   rem_s1, fade_s1;
	logic [fsts_pkg::AMP_W-1:0]    amp_s1;
	logic [fsts_pkg::POS_W-1:0]    pos_s1;

	logic                          vld_s2;
	fsts_pkg::div_t                dv_s2;

	logic                          div_vld_s [DivSteps];
	fsts_pkg::div_t                div_s     [DivSteps];
	fsts_pkg::div_t                div_src   [DivSteps];
	logic                          div_src_vld [DivSteps];
	logic                          div_ld    [DivSteps];

	logic                          vld_s3, past_s3, neg_s3;
	logic [fsts_pkg::AE_W-1:0]     ae_s3;
	logic [fsts_pkg::SK_W-1:0]     sk_s3;

	logic                          vld_s4, past_s4, neg_s4;
	logic [fsts_pkg::MAG_W-1:0]    mag_s4;

	logic                          vld_s5, past_s5;
	logic signed [fsts_pkg::VALUE_W-1:0] val_s5;

	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5;

	// Load chain, back from the output
	always_comb begin
		ld_s5 = !vld_s5 || !out_stall;
		ld_s4 = !vld_s4 || ld_s5;
		ld_s3 = !vld_s3 || ld_s4;
		div_ld[DivSteps-1] = !div_vld_s[DivSteps-1] || ld_s3;
		for (int i = DivSteps - 2; i >= 0; i--) begin
			div_ld[i] = !div_vld_s[i] || div_ld[i+1];
		end
		ld_s2 = !vld_s2 || div_ld[0];
		ld_s1 = !vld_s1 || ld_s2;
	end

	assign in_stall = !ld_s1;

	// Stage 1: phase multiply, past-end test, envelope numerator select
	logic [fsts_pkg::FADE_W-1:0]          fade_d;
	logic [fsts_pkg::CNT_W-1:0]           cnt_less_fade;
	logic [fsts_pkg::FADE_W-1:0]          num_d;
	logic                                 full_d;
	logic [fsts_pkg::IDX_W+fsts_pkg::STEP_W-1:0] phase_prod;
	logic [fsts_pkg::AMP_W-1:0]           amp_d;

	always_comb begin
		fade_d = sample_count_q[fsts_pkg::CNT_W-1:fsts_pkg::FADE_SHIFT];
		if (fade_d == '0) begin
			fade_d = fsts_pkg::FADE_W'(1);
		end
		cnt_less_fade = sample_count_q - fsts_pkg::CNT_W'(fade_d);
		priority if (sample_index < fsts_pkg::CNT_W'(fade_d)) begin
			full_d = 1'b0;
			num_d  = sample_index[fsts_pkg::FADE_W-1:0];
		end else if (sample_index > cnt_less_fade) begin
			full_d = 1'b0;
			num_d  = fsts_pkg::FADE_W'(sample_count_q - sample_index);
		end else begin
			full_d = 1'b1;
			num_d  = '0;
		end
		phase_prod = (fsts_pkg::IDX_W+fsts_pkg::STEP_W)'(sample_index)
			* (fsts_pkg::IDX_W+fsts_pkg::STEP_W)'(phase_step_q);
		amp_d = (amplitude_q > fsts_pkg::AMP_FULL) ? fsts_pkg::AMP_FULL : amplitude_q;
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			past_s1 <= sample_index >= sample_count_q;
			full_s1 <= full_d;
			rem_s1  <= num_d;
			fade_s1 <= fade_d;
			amp_s1  <= amp_d;
			pos_s1  <= phase_prod[fsts_pkg::PHASE_W-1 -: fsts_pkg::POS_W];
		end
	end

	// Stage 2: quadrant fold and registered ROM read
	logic [1:0]                  quad;
	logic [fsts_pkg::ADDR_W-1:0] off;
	logic [fsts_pkg::ADDR_W:0]   sidx;

	always_comb begin
		quad = pos_s1[fsts_pkg::POS_W-1 -: 2];
		off  = pos_s1[fsts_pkg::ADDR_W-1:0];
		sidx = quad[0] ? (fsts_pkg::ADDR_W+1)'(fsts_pkg::SINE_DEPTH) - {1'b0, off}
		               : {1'b0, off};
	end

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			dv_s2.sine    <= SineRom[sidx];
			dv_s2.quad_hi <= quad[1];
			dv_s2.past    <= past_s1;
			dv_s2.full    <= full_s1;
			dv_s2.amp     <= amp_s1;
			dv_s2.fade    <= fade_s1;
			dv_s2.rem     <= rem_s1;
			dv_s2.quo     <= '0;
		end
	end

	// Divider stages: envelope = (num << 16) / fade
	always_comb begin
		div_src[0]     = dv_s2;
		div_src_vld[0] = vld_s2;
		for (int i = 1; i < DivSteps; i++) begin
			div_src[i]     = div_s[i-1];
			div_src_vld[i] = div_vld_s[i-1];
		end
	end

	for (genvar g = 0; g < DivSteps; g++) begin : g_div
		always_ff @(posedge clk) begin
			if (div_ld[g]) begin
				div_s[g] <= fsts_pkg::div_step(div_src[g]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[g] <= 1'b0;
			end else if (div_ld[g]) begin
				div_vld_s[g] <= div_src_vld[g];
			end
		end
	end

	// Stage 3: envelope x amplitude, sine x tone scale
	fsts_pkg::div_t             dv_last;
	logic [fsts_pkg::ENV_W-1:0] env;

	always_comb begin
		dv_last = div_s[DivSteps-1];
		env = dv_last.full ? (fsts_pkg::ENV_W'(1) << DivSteps) : {1'b0, dv_last.quo};
	end

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			ae_s3   <= fsts_pkg::AE_W'(env) * fsts_pkg::AE_W'(dv_last.amp);
			sk_s3   <= fsts_pkg::SK_W'(dv_last.sine) * fsts_pkg::SK_W'(fsts_pkg::TONE_SCALE);
			neg_s3  <= dv_last.quad_hi && (dv_last.sine != '0);
			past_s3 <= dv_last.past;
		end
	end

	// Stage 4: full product, truncated
	logic [fsts_pkg::PROD_W-1:0] prod;

	assign prod = fsts_pkg::PROD_W'(ae_s3) * fsts_pkg::PROD_W'(sk_s3);

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			mag_s4  <= prod[fsts_pkg::RES_SHIFT +: fsts_pkg::MAG_W];
			neg_s4  <= neg_s3;
			past_s4 <= past_s3;
		end
	end

	// Stage 5: sign, past-end mask, output register
	always_ff @(posedge clk) begin
		if (ld_s5) begin
			past_s5 <= past_s4;
			if (past_s4) begin
				val_s5 <= '0;
			end else if (neg_s4) begin
				val_s5 <= -$signed(mag_s4);
			end else begin
				val_s5 <= $signed(mag_s4);
			end
		end
	end

	// Valid bits outside the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (ld_s1) vld_s1 <= in_valid;
			if (ld_s2) vld_s2 <= vld_s1;
			if (ld_s3) vld_s3 <= div_vld_s[DivSteps-1];
			if (ld_s4) vld_s4 <= vld_s3;
			if (ld_s5) vld_s5 <= vld_s4;
		end
	end

	assign out_valid    = vld_s5;
	assign sample_value = val_s5;
	assign past_end     = past_s5;

	// Input can only stall when every stage holds a word
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && vld_s2 && div_vld_s[0] && div_vld_s[DivSteps-1]
			&& vld_s3 && vld_s4 && vld_s5))
		else $error("input stalled with an empty stage");

	// Past-end words carry a zero sample
	a_past_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && past_end |-> sample_value == '0)
		else $error("past_end word with nonzero sample");

	// Scaled magnitude never exceeds the tone scale
	a_mag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$past(ld_s4) && $past(vld_s3) |-> mag_s4 <= fsts_pkg::MAG_W'(fsts_pkg::TONE_SCALE))
		else $error("magnitude above tone scale");

endmodule

// ----- dv/tone_sample_monitor.sv -----
`timescale 1ns / 100ps

// Watches all three ports, mirrors the registers and scores every output word.
module tone_sample_monitor (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write_en,
	input  logic [fsts_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fsts_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic [fsts_pkg::IDX_W-1:0]           sample_index,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [fsts_pkg::VALUE_W-1:0]  sample_value,
	input  logic                                 past_end,
	output int                                   errors,
	output int                                   outstanding,
	output int                                   compared
);

	typedef struct packed {
		logic signed [fsts_pkg::VALUE_W-1:0] value;
		logic                                past;
	} tone_word_t;

	logic [fsts_pkg::STEP_W-1:0] step_q;
	logic [fsts_pkg::AMP_W-1:0]  amp_q;
	logic [fsts_pkg::CNT_W-1:0]  count_q;
	int unsigned                 quarter_wave [0:fsts_pkg::SINE_DEPTH];
	tone_word_t                  expected_samples [$];
	tone_word_t                  want;

	// Q30 Taylor series, rounded to Q15, capped at 32767
	initial begin
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] q;
		for (int k = 0; k <= fsts_pkg::SINE_DEPTH; k++) begin
			x = (64'(k) * fsts_pkg::HALF_PI_Q30) / 64'(fsts_pkg::SINE_DEPTH);
			x2 = (x * x) >> 30;
			term = x;
			sum = x;
			for (int n = 1; n <= 7; n++) begin
				term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1)
					sum = (sum >= term) ? sum - term : 64'd0;
				else
					sum = sum + term;
			end
			q = (sum + 64'd16384) >> 15;
			if (q > 64'd32767)
				q = 64'd32767;
			quarter_wave[k] = int'(q);
		end
	end

	function automatic tone_word_t tone_sample_of(logic [fsts_pkg::IDX_W-1:0] idx);
		tone_word_t  w;
		logic [31:0] fade;
		logic [31:0] env;
		logic [31:0] amp;
		logic [31:0] phase;
		logic [63:0] pos;
		logic [1:0]  quad;
		int unsigned off;
		int unsigned sidx;
		int unsigned s;
		logic [63:0] mag;
		w.value = '0;
		w.past = 1'b1;
		if (idx >= count_q)
			return w;
		w.past = 1'b0;
		fade = 32'(count_q) >> fsts_pkg::FADE_SHIFT;
		if (fade == 0)
			fade = 1;
		if (32'(idx) < fade)
			env = (32'(idx) << 16) / fade;
		else if (32'(idx) > 32'(count_q) - fade)
			env = ((32'(count_q) - 32'(idx)) << 16) / fade;
		else
			env = 32'h1_0000;
		phase = 32'(64'(idx) * 64'(step_q));
		pos = (64'(phase) * 64'(4 * fsts_pkg::SINE_DEPTH)) >> 32;
		quad = 2'(pos / 64'(fsts_pkg::SINE_DEPTH));
		off = int'(pos % 64'(fsts_pkg::SINE_DEPTH));
		sidx = quad[0] ? fsts_pkg::SINE_DEPTH - off : off;
		s = quarter_wave[sidx];
		amp = (amp_q > fsts_pkg::AMP_FULL) ? 32'(fsts_pkg::AMP_FULL) : 32'(amp_q);
		mag = (64'(s) * 64'(amp) * 64'(env) * 64'(fsts_pkg::TONE_SCALE))
			>> fsts_pkg::RES_SHIFT;
		w.value = (quad[1] && s != 0) ? -fsts_pkg::VALUE_W'(mag)
			: fsts_pkg::VALUE_W'(mag);
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q = fsts_pkg::PHASE_STEP_RST;
			amp_q = fsts_pkg::AMPLITUDE_RST;
			count_q = fsts_pkg::SAMPLE_COUNT_RST;
			expected_samples.delete();
			errors = 0;
			compared = 0;
			outstanding = 0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					fsts_pkg::CFG_PHASE_STEP:
						step_q = cfg_data[fsts_pkg::STEP_W-1:0];
					fsts_pkg::CFG_AMPLITUDE:
						amp_q = cfg_data[fsts_pkg::AMP_W-1:0];
					fsts_pkg::CFG_SAMPLE_COUNT:
						count_q = cfg_data[fsts_pkg::CNT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_samples.push_back(tone_sample_of(sample_index));
			if (out_valid && !out_stall) begin
				compared++;
				if (expected_samples.size() == 0) begin
					errors++;
					$display("%0t: unexpected word: expected none, got value %0d past_end %0b",
						$time, sample_value, past_end);
				end else begin
					want = expected_samples.pop_front();
					if (sample_value !== want.value) begin
						errors++;
						$display("%0t: sample_value expected %0d, got %0d",
							$time, want.value, sample_value);
					end
					if (past_end !== want.past) begin
						errors++;
						$display("%0t: past_end expected %0b, got %0b",
							$time, want.past, past_end);
					end
				end
			end
			outstanding = expected_samples.size();
		end
	end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

// Stimulus and verdict for the tone sample core. Scoring lives in the monitor.
module tb;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int TAIL_CYCLES   = 40;     // longer than the pipeline is deep
	localparam int RANDOM_WORDS  = 1950;
	localparam int PHASES        = 13;
	localparam int PHASE_WORDS   = RANDOM_WORDS / PHASES;

	// index 3 decodes to nothing; writes there must be dropped
	localparam logic [fsts_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

	typedef enum int {FLOW_OPEN, FLOW_SRC_GAPS, FLOW_SINK_STALLS, FLOW_BOTH} flow_t;

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_write_en;
	logic [fsts_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic [fsts_pkg::CFG_DATA_W-1:0]     cfg_data;
	logic                                in_valid;
	logic                                in_stall;
	logic [fsts_pkg::IDX_W-1:0]          sample_index;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic signed [fsts_pkg::VALUE_W-1:0] sample_value;
	logic                                past_end;

	int errors;
	int outstanding;
	int compared;

	int          gap_pct;
	int          stall_pct;
	int          words;
	int          settings;
	int          cycles;
	logic [fsts_pkg::CNT_W-1:0] cur_count;   // stimulus-side copy, used to aim indices

	faded_sine_tone_sample_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_index (sample_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_value (sample_value),
		.past_end     (past_end)
	);

	tone_sample_monitor mon (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_index (sample_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_value (sample_value),
		.past_end     (past_end),
		.errors       (errors),
		.outstanding  (outstanding),
		.compared     (compared)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sink side: random back-pressure, redrawn every falling edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still owed", cycles, outstanding);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Offer one word. Entered and left just after a falling edge; in_valid
	// is left high so back-to-back words go without a gap in valid.
	task automatic send_word(input logic [fsts_pkg::IDX_W-1:0] idx);
		logic taken;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample_index <= idx;
		words++;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !in_stall;   // pre-edge value: accepted on this edge
			@(negedge clk);
		end
	endtask

	// Hold off the source until every word in flight has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// One write, then write enable is dropped before the task returns, so write enables never abut.
	task automatic write_reg(input logic [fsts_pkg::CFG_IDX_W-1:0] idx,
			input logic [fsts_pkg::CFG_DATA_W-1:0] data);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		@(negedge clk);
		if (idx == fsts_pkg::CFG_SAMPLE_COUNT)
			cur_count = data[fsts_pkg::CNT_W-1:0];
	endtask

	// Registers only change with the pipe empty.
	task automatic set_tone(input logic [fsts_pkg::STEP_W-1:0] step,
			input logic [fsts_pkg::AMP_W-1:0] amp,
			input logic [fsts_pkg::CNT_W-1:0] cnt);
		drain();
		write_reg(fsts_pkg::CFG_PHASE_STEP, fsts_pkg::CFG_DATA_W'(step));
		write_reg(fsts_pkg::CFG_AMPLITUDE, fsts_pkg::CFG_DATA_W'(amp));
		write_reg(fsts_pkg::CFG_SAMPLE_COUNT, fsts_pkg::CFG_DATA_W'(cnt));
		settings++;
	endtask

	task automatic set_flow(input flow_t mode);
		case (mode)
			FLOW_OPEN:        begin gap_pct = 0;  stall_pct = 0;  end
			FLOW_SRC_GAPS:    begin gap_pct = 48; stall_pct = 0;  end
			FLOW_SINK_STALLS: begin gap_pct = 0;  stall_pct = 48; end
			default:          begin gap_pct = 36; stall_pct = 36; end
		endcase
	endtask

	// Mostly in-range indices, with weight on the fade knees, the tone end
	// and the odd wild index anywhere in the 16-bit range.
	function automatic logic [fsts_pkg::IDX_W-1:0] pick_index();
		int c;
		int f;
		int v;
		c = int'(cur_count);
		f = c / 8;
		if (f == 0)
			f = 1;
		case ($urandom_range(9))
			0: v = int'($urandom_range(65535));
			1: v = f + int'($urandom_range(4)) - 2;
			2: v = c - f + int'($urandom_range(4)) - 2;
			3: v = c + int'($urandom_range(3)) - 2;
			default: v = (c == 0) ? int'($urandom_range(65535)) : int'($urandom_range(c - 1));
		endcase
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return fsts_pkg::IDX_W'(v);
	endfunction

	initial begin
		logic [fsts_pkg::STEP_W-1:0] step;
		logic [fsts_pkg::AMP_W-1:0]  amp;
		logic [fsts_pkg::CNT_W-1:0]  cnt;
		cycles = 0;
		words = 0;
		settings = 1;
		gap_pct = 0;
		stall_pct = 0;
		cur_count = fsts_pkg::SAMPLE_COUNT_RST;
		in_valid = 1'b0;
		sample_index = '0;
		cfg_write_en = 1'b0;
		cfg_index = fsts_pkg::CFG_PHASE_STEP;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		set_flow(FLOW_OPEN);

		// Reset tone: 2205 samples, fade of 275. Hit both knees, the last
		// sample, the first one past the end and the top index.
		send_word(16'd0);
		send_word(16'd1);
		send_word(16'd274);
		send_word(16'd275);
		send_word(16'd1930);
		send_word(16'd1931);
		send_word(16'd2204);
		send_word(16'd2205);
		send_word(16'hFFFF);

		// A write to the unmapped index must leave all registers alone.
		drain();
		write_reg(CFG_UNMAPPED, '1);
		send_word(16'd1000);
		send_word(16'd100);

		// Short tone: fade clamps to one sample; amplitude saturates.
		set_tone('1, '1, 16'd5);
		send_word(16'd0);
		send_word(16'd2);
		send_word(16'd4);
		send_word(16'd5);

		// Zero-length tone is past the end everywhere; zero amplitude is silence.
		set_tone('0, fsts_pkg::AMP_FULL, 16'd0);
		send_word(16'd0);
		send_word(16'hFFFF);
		set_tone(fsts_pkg::PHASE_STEP_RST, '0, '1);
		send_word(16'd30000);
		send_word(16'hFFFE);
		set_tone(fsts_pkg::PHASE_STEP_RST, fsts_pkg::AMP_FULL, '1);
		send_word(16'd8191);
		send_word(16'd20000);
		send_word(16'hFFFE);

		// Random phases: each picks a register setting and a flow mode,
		// cycling through all four modes several times.
		for (int p = 0; p < PHASES; p++) begin
			case (p % 5)
				1:       step = fsts_pkg::STEP_W'($urandom_range(500000000, 1));
				2:       step = '1;
				4:       step = (p == 4) ? '0 : fsts_pkg::STEP_W'($urandom);
				default: step = fsts_pkg::STEP_W'($urandom);
			endcase
			case (p % 4)
				0:       amp = fsts_pkg::AMP_FULL;
				1:       amp = fsts_pkg::AMP_W'($urandom_range(32768));
				2:       amp = (p == 2) ? '1 : fsts_pkg::AMP_W'($urandom_range(65535));
				default: amp = (p == 3) ? '0 : fsts_pkg::AMP_W'($urandom_range(32768, 1));
			endcase
			case (p % 6)
				0:       cnt = '1;
				1:       cnt = fsts_pkg::CNT_W'($urandom_range(7, 1));
				2:       cnt = 16'd8;
				3:       cnt = fsts_pkg::CNT_W'($urandom_range(300, 9));
				4:       cnt = fsts_pkg::CNT_W'($urandom_range(4000, 1));
				default: cnt = fsts_pkg::CNT_W'($urandom_range(65535));
			endcase
			set_tone(step, amp, cnt);
			set_flow(flow_t'(p % 4));
			for (int i = 0; i < PHASE_WORDS; i++) begin
				// now and then starve the pipe completely mid-phase
				if (p % 4 == 1 && i == PHASE_WORDS / 2)
					drain();
				send_word(pick_index());
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("%0d sample indices across %0d register settings, %0d words scored,",
			words, settings, compared);
		$display("with open flow, source gaps, sink stalls and both together");
		if (errors == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
